FILE: sv/saa_pkg.sv
// Package for the shelf atlas allocator: field widths, request codes,
// item and result structs. No dependencies.

package saa_pkg;

	localparam int SIZE_W  = 13;    // request sizes and atlas side
	localparam int COORD_W = 14;    // placements and dirty rectangle
	localparam int SUM_W   = COORD_W + 1;

	localparam logic [SIZE_W-1:0] SIDE_RESET = SIZE_W'(1024);
	localparam int                MAX_SIDE   = 4096;

	localparam logic MODE_RESERVE = 1'b0;
	localparam logic MODE_CLEAR   = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [SIZE_W-1:0] req_width;
		logic [SIZE_W-1:0] req_height;
	} saa_item_t;

	typedef struct packed {
		logic               granted;
		logic [COORD_W-1:0] place_x;
		logic [COORD_W-1:0] place_y;
		logic               overflow_seen;
		logic               any_dirty;
		logic [COORD_W-1:0] dirty_left;
		logic [COORD_W-1:0] dirty_top;
		logic [COORD_W-1:0] dirty_w;
		logic [COORD_W-1:0] dirty_h;
	} saa_result_t;

endpackage

FILE: sv/saa_core.sv
// Shelf state registers and the combinational allocation logic.
// Depends on saa_pkg.

module saa_core
	import saa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  saa_item_t         item,
	input  logic [SIZE_W-1:0] side_cfg,
	output saa_result_t       res
);

	logic [COORD_W-1:0] cur_q, base_q;
	logic [SIZE_W-1:0]  tall_q;
	logic               ovf_q, dval_q;
	logic [COORD_W-1:0] left_q, top_q, bw_q, bh_q;

	logic [COORD_W-1:0] cur_n, base_n;
	logic [SIZE_W-1:0]  tall_n;
	logic               ovf_n, dval_n;
	logic [COORD_W-1:0] left_n, top_n, bw_n, bh_n;

	logic [SIZE_W-1:0]  side;
	logic [SUM_W-1:0]   side_x, w_x, h_x;
	logic [SUM_W-1:0]   c_sum, ny, base_sh, cur_sh, place_sum;
	logic [SUM_W-1:0]   r_old, r_new, r_max, b_old, b_new, b_max;
	logic [COORD_W-1:0] cur_a, base_a, l_min, t_min;
	logic [SIZE_W-1:0]  tall_a;
	logic               new_shelf, refuse, ok;

	// side in use: 0 acts as 1, anything above the limit acts as the limit
	always_comb begin
		if (side_cfg == '0) begin
			side = SIZE_W'(1);
		end else if (SUM_W'(side_cfg) > SUM_W'(MAX_SIDE)) begin
			side = SIZE_W'(MAX_SIDE);
		end else begin
			side = side_cfg;
		end
	end

	assign side_x = SUM_W'(side);
	assign w_x    = SUM_W'(item.req_width);
	assign h_x    = SUM_W'(item.req_height);

	// shelf change, taken before the fit test and kept even on refusal
	assign c_sum     = SUM_W'(cur_q) + w_x + SUM_W'(1);
	assign new_shelf = c_sum > side_x;
	assign ny        = SUM_W'(base_q) + SUM_W'(tall_q) + SUM_W'(1);
	assign base_sh   = (ny > side_x) ? side_x : ny;
	assign cur_a     = new_shelf ? '0 : cur_q;
	assign base_a    = new_shelf ? base_sh[COORD_W-1:0] : base_q;
	assign tall_a    = new_shelf ? '0 : tall_q;

	assign refuse    = (SUM_W'(base_a) + h_x > side_x) || (w_x > side_x);
	assign cur_sh    = SUM_W'(cur_a) + w_x + SUM_W'(1);
	assign place_sum = SUM_W'(base_a) + h_x;

	// dirty rectangle growth around the placement at (cur_a, base_a)
	assign r_old = SUM_W'(left_q) + SUM_W'(bw_q);
	assign r_new = SUM_W'(cur_a) + w_x;
	assign r_max = (r_new > r_old) ? r_new : r_old;
	assign b_old = SUM_W'(top_q) + SUM_W'(bh_q);
	assign b_new = place_sum;
	assign b_max = (b_new > b_old) ? b_new : b_old;
	assign l_min = (left_q < cur_a) ? left_q : cur_a;
	assign t_min = (top_q < base_a) ? top_q : base_a;

	always_comb begin
		cur_n  = cur_q;
		base_n = base_q;
		tall_n = tall_q;
		ovf_n  = ovf_q;
		dval_n = dval_q;
		left_n = left_q;
		top_n  = top_q;
		bw_n   = bw_q;
		bh_n   = bh_q;
		ok     = 1'b0;
		if (item.mode == MODE_CLEAR) begin
			cur_n  = '0;
			base_n = '0;
			tall_n = '0;
			ovf_n  = 1'b0;
			dval_n = 1'b1;
			left_n = '0;
			top_n  = '0;
			bw_n   = COORD_W'(side);
			bh_n   = COORD_W'(side);
		end else if (item.req_width != '0 && item.req_height != '0) begin
			cur_n  = cur_a;
			base_n = base_a;
			tall_n = tall_a;
			if (refuse) begin
				ovf_n = 1'b1;
			end else begin
				ok     = 1'b1;
				cur_n  = cur_sh[COORD_W-1:0];
				tall_n = (item.req_height > tall_a) ? item.req_height : tall_a;
				dval_n = 1'b1;
				if (!dval_q) begin
					left_n = cur_a;
					top_n  = base_a;
					bw_n   = COORD_W'(item.req_width);
					bh_n   = COORD_W'(item.req_height);
				end else begin
					left_n = l_min;
					top_n  = t_min;
					bw_n   = COORD_W'(r_max - SUM_W'(l_min));
					bh_n   = COORD_W'(b_max - SUM_W'(t_min));
				end
			end
		end
	end

	always_comb begin
		res.granted       = ok;
		res.place_x       = ok ? cur_a : '0;
		res.place_y       = ok ? base_a : '0;
		res.overflow_seen = ovf_n;
		res.any_dirty     = dval_n;
		res.dirty_left    = left_n;
		res.dirty_top     = top_n;
		res.dirty_w       = bw_n;
		res.dirty_h       = bh_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			base_q <= '0;
			tall_q <= '0;
			ovf_q  <= 1'b0;
			dval_q <= 1'b0;
			left_q <= '0;
			top_q  <= '0;
			bw_q   <= '0;
			bh_q   <= '0;
		end else if (adv) begin
			cur_q  <= cur_n;
			base_q <= base_n;
			tall_q <= tall_n;
			ovf_q  <= ovf_n;
			dval_q <= dval_n;
			left_q <= left_n;
			top_q  <= top_n;
			bw_q   <= bw_n;
			bh_q   <= bh_n;
		end
	end

	a_clear_resets: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item.mode == MODE_CLEAR |=> !ovf_q && cur_q == '0 && base_q == '0 && dval_q)
		else $error("clear did not reset shelf state");

	a_grant_keeps_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		res.granted |-> res.overflow_seen == ovf_q && res.any_dirty)
		else $error("grant changed overflow flag or left dirty box empty");

	a_clean_box_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!dval_q |-> left_q == '0 && top_q == '0 && bw_q == '0 && bh_q == '0)
		else $error("dirty box nonzero while not valid");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(cur_q) && $stable(base_q) && $stable(ovf_q))
		else $error("shelf state moved without a transfer");

endmodule

FILE: sv/shelf_atlas_allocator_unit.sv
// Top level of the shelf atlas allocator: request stage, result register,
// atlas side register. Depends on saa_pkg and saa_core.
//
// Usage:
//   Requests arrive on req_valid/req_ready with mode, req_width, req_height.
//   mode MODE_RESERVE asks for a region, MODE_CLEAR empties the atlas.
//   Every request produces exactly one result on rsp_valid/rsp_ready.
//   A request is taken into a request register; the shelf logic evaluates it
//   against the stored shelf state and loads the result register, raising
//   rsp_valid, once that register is free or being read.
//   Throughput is one request per cycle while the receiver does not stall;
//   the shelf state update is a single add/compare pass, which sets that
//   limit. If the receiver stalls, the result register holds and the request
//   register fills; req_ready drops only when both are occupied.
//   The atlas side is written through cfg_we/cfg_wdata; the user must write
//   it only while idle, the block itself does not enforce this.
//   Reset clears all shelf state, the overflow flag and the dirty box, empties
//   both registers and sets the atlas side to 1024.

module shelf_atlas_allocator_unit
	import saa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [SIZE_W-1:0]  cfg_wdata,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic               mode,
	input  logic [SIZE_W-1:0]  req_width,
	input  logic [SIZE_W-1:0]  req_height,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic               granted,
	output logic [COORD_W-1:0] place_x,
	output logic [COORD_W-1:0] place_y,
	output logic               overflow_seen,
	output logic               any_dirty,
	output logic [COORD_W-1:0] dirty_left,
	output logic [COORD_W-1:0] dirty_top,
	output logic [COORD_W-1:0] dirty_w,
	output logic [COORD_W-1:0] dirty_h
);

	logic [SIZE_W-1:0] side_q;
	logic              vld_s1, vld_s2;
	saa_item_t         item_s1;
	saa_result_t       res, res_s2;
	logic              adv;

	assign adv       = vld_s1 && (!vld_s2 || rsp_ready);
	assign req_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_RESET;
		end else if (cfg_we) begin
			side_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				vld_s1 <= req_valid;
			end
			if (adv) begin
				vld_s2 <= 1'b1;
			end else if (rsp_ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= '{mode: mode, req_width: req_width, req_height: req_height};
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	saa_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.item     (item_s1),
		.side_cfg (side_q),
		.res      (res)
	);

	assign rsp_valid     = vld_s2;
	assign granted       = res_s2.granted;
	assign place_x       = res_s2.place_x;
	assign place_y       = res_s2.place_y;
	assign overflow_seen = res_s2.overflow_seen;
	assign any_dirty     = res_s2.any_dirty;
	assign dirty_left    = res_s2.dirty_left;
	assign dirty_top     = res_s2.dirty_top;
	assign dirty_w       = res_s2.dirty_w;
	assign dirty_h       = res_s2.dirty_h;

endmodule
